>>> sv/keyboard_packet_to_key_matrix_core_defines.svh
`ifndef KEYBOARD_PACKET_TO_KEY_MATRIX_CORE_DEFINES_SVH
`define KEYBOARD_PACKET_TO_KEY_MATRIX_CORE_DEFINES_SVH

// same-cycle implication check
`define KPKM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpkm check failed");

// next-cycle implication check
`define KPKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpkm check failed");

`endif

>>> sv/kpkm_pkg.sv
`timescale 1ns / 1ps
package kpkm_pkg;

    localparam int ROWS = 19;
    localparam int RAM_ROWS = 16;

    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_GAME = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam int ST_CTRL   = 0;
    localparam int ST_SHIFT  = 1;
    localparam int ST_KANA   = 2;
    localparam int ST_REPEAT = 5;
    localparam int ST_KEYIN  = 6;
    localparam int ST_TENKEY = 7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  key_code;
        logic [7:0]  status_byte;
        logic [23:0] joy_bits;
        logic [4:0]  row_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] row_data;
        logic        game_mode_active;
    } t_out_item;

    // one pipe access: read a RAM or high row, or clear/set bits
    typedef struct packed {
        logic        rd;
        logic [3:0]  row;
        logic [15:0] clr;
        logic [15:0] set;
        logic        hi;
        logic [15:0] hdata;
        logic        gm;
    } t_op;

    typedef struct packed {
        logic [7:0]  last_key;
        logic        skh;
        logic [23:0] lgb;
        logic        gm;
        logic [15:0] r16;
        logic [15:0] r17;
        logic [15:0] r18;
    } t_state;

    localparam logic [7:0] KEYPAD_MAP [17] = '{
        8'h9B, 8'h9D, 8'h9F, 8'h9C, 8'h91, 8'h9E, 8'h8F, 8'h99,
        8'h92, 8'h98, 8'h95, 8'h96, 8'h94, 8'h9A, 8'h93, 8'h97, 8'h90
    };

    localparam logic [7:0] KANA_FIX [64] = '{
        8'hA0, 8'hA5, 8'hA2, 8'hA3, 8'hDF, 8'hDB, 8'hD2, 8'hC7,
        8'hCC, 8'hA7, 8'hA9, 8'hAA, 8'hD0, 8'hD3, 8'hA4, 8'hBF,
        8'hB9, 8'hC7, 8'hCC, 8'hB1, 8'hB3, 8'hB4, 8'hC0, 8'hC3,
        8'hB2, 8'hBD, 8'hB6, 8'hC1, 8'hC4, 8'hBC, 8'hCA, 8'hB7,
        8'hC2, 8'hBB, 8'hBF, 8'hCB, 8'hBA, 8'hB5, 8'hD4, 8'hD5,
        8'hD6, 8'hDC, 8'hDD, 8'hC5, 8'hC6, 8'hD7, 8'hBE, 8'hB8,
        8'hCF, 8'hC9, 8'hD8, 8'hDA, 8'hD0, 8'hD3, 8'hC8, 8'hCE,
        8'hCD, 8'hB0, 8'hDE, 8'hDF, 8'hD9, 8'hDB, 8'hB9, 8'hA3
    };

    function automatic logic [4:0] game_bit(input logic [7:0] c);
        logic [4:0] b;
        case (c)
            8'h11, 8'h51, 8'h71, 8'hC0, 8'hE0:        b = 5'd24;
            8'h17, 8'h57, 8'h77, 8'hC3, 8'hE1:        b = 5'd23;
            8'h05, 8'h45, 8'h65, 8'hA8, 8'hB2, 8'hE2: b = 5'd22;
            8'h01, 8'h41, 8'h61, 8'h7F, 8'hC1:        b = 5'd21;
            8'h04, 8'h44, 8'h64, 8'hBC, 8'hEA:        b = 5'd20;
            8'h1A, 8'h5A, 8'h7A, 8'h80, 8'hAF, 8'hC2: b = 5'd19;
            8'h18, 8'h58, 8'h78, 8'hBB:               b = 5'd18;
            8'h43, 8'h63, 8'h81, 8'hBF:               b = 5'd17;
            8'h9A: b = 5'd16;
            8'h95: b = 5'd15;
            8'h99: b = 5'd14;
            8'h93: b = 5'd13;
            8'h92: b = 5'd12;
            8'h97: b = 5'd11;
            8'h94: b = 5'd10;
            8'h98: b = 5'd9;
            8'h1B: b = 5'd8;
            8'h21, 8'h31, 8'hC7, 8'hF1: b = 5'd7;
            8'h9C: b = 5'd6;
            8'h9D: b = 5'd5;
            8'h9B: b = 5'd4;
            8'h09: b = 5'd3;
            8'h20: b = 5'd2;
            8'h0D: b = 5'd1;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

endpackage

>>> sv/kpkm_ram.sv
`timescale 1ns / 1ps
module kpkm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/kpkm_decode.sv
`timescale 1ns / 1ps
module kpkm_decode import kpkm_pkg::*; (
    input  t_in_item   i_item,
    input  t_state     i_state,
    output t_state     o_state,
    output t_op        o_op0,
    output t_op        o_op1,
    output logic [1:0] o_nops
);
    function automatic logic leave_game(input logic [7:0] c, input logic [7:0] st,
                                        input logic gm, input logic [23:0] lgb);
        logic [4:0] b;
        logic       r;
        b = game_bit(c);
        r = gm;
        if (gm && b != 5'd0 && !lgb[b - 5'd1]) begin
            if (c == 8'h1B || c == 8'h0D || c == 8'h09) begin
                if (st[ST_CTRL]) begin
                    r = 1'b0;
                end
            end else begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    t_state     s;
    t_op        op0;
    t_op        op1;
    logic [1:0] nops;
    logic [7:0] code;
    logic [7:0] st;
    logic [7:0] kc;
    logic [7:0] plain;
    logic [7:0] d;
    logic [7:0] f;
    logic [7:0] rel_k;
    logic [7:0] prs_k;
    logic       rel_v;
    logic       prs_v;
    logic       done;
    logic       is_spec;
    logic       spec_press;
    logic [5:0] spec_addr;

    always_comb begin
        s          = i_state;
        op0        = '0;
        op1        = '0;
        nops       = 2'd0;
        code       = i_item.key_code;
        st         = i_item.status_byte;
        kc         = '0;
        plain      = '0;
        d          = '0;
        f          = '0;
        rel_k      = i_state.last_key;
        prs_k      = '0;
        rel_v      = 1'b0;
        prs_v      = 1'b0;
        done       = 1'b0;
        is_spec    = 1'b0;
        spec_press = 1'b0;
        spec_addr  = '0;
        case (i_item.req_type)
            REQ_CHAR: begin
                if (st[ST_REPEAT]) begin
                    if (!s.skh) begin
                        rel_v = 1'b1;
                    end else begin
                        s.r16 = s.r16 & 16'h001F;
                        s.r18 = s.r18 & 16'h00FF;
                        s.skh = 1'b0;
                    end
                    if (!(code == 8'h00 && (st[ST_KEYIN] || st[ST_CTRL]))) begin
                        if (!st[ST_TENKEY]) begin
                            is_spec    = 1'b1;
                            spec_press = 1'b1;
                            if (code >= 8'h2A && code <= 8'h39) begin
                                d       = code - 8'h2A;
                                code    = KEYPAD_MAP[d[4:0]];
                                is_spec = 1'b0;
                            end else if (code == 8'h3D) begin
                                code    = KEYPAD_MAP[16];
                                is_spec = 1'b0;
                            end else if (code == 8'hE1) begin
                                spec_addr = 6'h05;
                            end else if (code == 8'hE2) begin
                                spec_addr = 6'h06;
                            end else if (code == 8'hE8) begin
                                spec_addr = 6'h07;
                            end else if (code == 8'hEB) begin
                                spec_addr = 6'h08;
                            end else if (code == 8'hEC) begin
                                spec_addr = 6'h09;
                            end else if (code == 8'h0D) begin
                                s.gm       = leave_game(code, st, s.gm, s.lgb);
                                spec_press = !s.gm;
                                spec_addr  = 6'h0A;
                            end else if (code == 8'h0B || code == 8'h0C) begin
                                spec_addr = 6'h0B;
                            end else if (code >= 8'h1C && code <= 8'h1F) begin
                                spec_addr = {2'b00, code[3:0]};
                            end else if (code >= 8'h71 && code <= 8'h7A) begin
                                f         = (code > 8'h75) ? code - 8'd5 : code;
                                spec_addr = 6'h28 + {2'b00, f[3:0]};
                            end else begin
                                is_spec = 1'b0;
                            end
                            if (is_spec) begin
                                if (spec_press) begin
                                    case (spec_addr[5:4])
                                        2'd0: s.r16[spec_addr[3:0]] = 1'b1;
                                        2'd1: s.r17[spec_addr[3:0]] = 1'b1;
                                        2'd2: s.r18[spec_addr[3:0]] = 1'b1;
                                        default: ;
                                    endcase
                                end
                                done  = 1'b1;
                                s.skh = 1'b1;
                            end
                        end else if (!st[ST_CTRL] && st[ST_SHIFT]) begin
                            if (code == 8'h03) begin
                                prs_v = 1'b1;
                                prs_k = 8'h43;
                                done  = 1'b1;
                            end else if (code == 8'h12) begin
                                prs_v = 1'b1;
                                prs_k = 8'h52;
                                done  = 1'b1;
                            end
                        end
                        if (!done) begin
                            plain = code;
                            kc    = code;
                            if (s.gm && !st[ST_KANA] && code >= 8'hA0 && code <= 8'hDF) begin
                                d  = code - 8'hA0;
                                kc = KANA_FIX[d[5:0]];
                            end
                            s.gm = leave_game(kc, st, s.gm, s.lgb);
                            if (!s.gm) begin
                                prs_v = 1'b1;
                                prs_k = plain;
                            end else if (game_bit(kc) == 5'd0) begin
                                prs_v = 1'b1;
                                prs_k = kc;
                            end
                        end
                        if (prs_v) begin
                            s.last_key = prs_k;
                        end
                    end
                end
                s.r16 = {s.r16[15:5], ~st[4:0]};
            end
            REQ_GAME: begin
                s.gm       = 1'b1;
                s.r17      = i_item.joy_bits[15:0];
                s.r18[7:0] = i_item.joy_bits[23:16];
                s.lgb      = i_item.joy_bits;
            end
            REQ_READ: begin
                op0.rd = 1'b1;
                op0.gm = i_state.gm;
                nops   = 2'd1;
                if (i_item.row_index < 5'(RAM_ROWS)) begin
                    op0.row = i_item.row_index[3:0];
                end else begin
                    op0.hi = 1'b1;
                    case (i_item.row_index)
                        5'd16:   op0.hdata = i_state.r16;
                        5'd17:   op0.hdata = i_state.r17;
                        5'd18:   op0.hdata = i_state.r18;
                        default: op0.hdata = '0;
                    endcase
                end
            end
            default: ;
        endcase

        if (rel_v && prs_v && rel_k[7:4] == prs_k[7:4]) begin
            op0.row = rel_k[7:4];
            op0.clr = 16'h0001 << rel_k[3:0];
            op0.set = 16'h0001 << prs_k[3:0];
            nops    = 2'd1;
        end else if (rel_v && prs_v) begin
            op0.row = rel_k[7:4];
            op0.clr = 16'h0001 << rel_k[3:0];
            op1.row = prs_k[7:4];
            op1.set = 16'h0001 << prs_k[3:0];
            nops    = 2'd2;
        end else if (rel_v) begin
            op0.row = rel_k[7:4];
            op0.clr = 16'h0001 << rel_k[3:0];
            nops    = 2'd1;
        end else if (prs_v) begin
            op0.row = prs_k[7:4];
            op0.set = 16'h0001 << prs_k[3:0];
            nops    = 2'd1;
        end
    end

    assign o_state = s;
    assign o_op0   = op0;
    assign o_op1   = op1;
    assign o_nops  = nops;
endmodule

>>> sv/keyboard_packet_to_key_matrix_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake         | payload
// in      | to core   | i_valid / o_stall | i_item (t_in_item)
// out     | from core | o_valid / i_stall | o_item (t_out_item)
//
// Rows 0..15 live in a 16-entry RAM; rows 16..18 and the scalar state in flops.
// An item is decoded when taken and yields up to two RAM accesses, issued one a
// cycle, unless a stalled output holds the pipe, through a read / modify / write pipe;
// o_stall stays high, and no new item is taken, until the accesses of the last are issued.
// A row read passes r_pop, r_s1 and r_s2 and is then registered into o_item.
// Reset clears the RAM valid bits at once; no clearing pass is needed.
// A stalled output holds the pipe only while a read waits at its end.
module keyboard_packet_to_key_matrix_core import kpkm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
`include "keyboard_packet_to_key_matrix_core_defines.svh"

    t_state          r_st;
    t_state          n_st;
    t_op             dec_op0;
    t_op             dec_op1;
    logic [1:0]      dec_nops;
    t_op             r_pop [2];
    logic [1:0]      r_pcnt;
    t_op             r_s1;
    logic            r_s1v;
    t_op             r_s2;
    logic            r_s2v;
    logic            r_s2vld;
    logic [RAM_ROWS-1:0] r_vld;
    logic            r_fv;
    logic [3:0]      r_frow;
    logic [15:0]     r_fdata;
    logic            r_ov;
    t_out_item       r_out;
    logic [15:0]     ram_rdata;
    logic [15:0]     old_row;
    logic [15:0]     new_row;
    logic            ram_we;
    logic            adv;
    logic            accept;

    kpkm_decode u_decode (
        .i_item  (i_item),
        .i_state (r_st),
        .o_state (n_st),
        .o_op0   (dec_op0),
        .o_op1   (dec_op1),
        .o_nops  (dec_nops)
    );

    kpkm_ram #(.WIDTH(16), .DEPTH(RAM_ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2.row),
        .i_wdata (new_row),
        .i_re    (adv),
        .i_raddr (r_s1.row),
        .o_rdata (ram_rdata)
    );

    assign o_stall = (r_pcnt != 2'd0);
    assign accept  = i_valid && !o_stall;
    assign adv     = !(r_s2v && r_s2.rd && r_ov && i_stall);

    always_comb begin
        if (r_fv && r_frow == r_s2.row) begin
            old_row = r_fdata;
        end else if (r_s2vld) begin
            old_row = ram_rdata;
        end else begin
            old_row = '0;
        end
        new_row = (old_row & ~r_s2.clr) | r_s2.set;
        ram_we  = adv && r_s2v && !r_s2.rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_pcnt <= 2'd0;
            r_s1v  <= 1'b0;
            r_s2v  <= 1'b0;
            r_vld  <= '0;
            r_fv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (accept) begin
                r_st   <= n_st;
                r_pcnt <= dec_nops;
            end else if (adv && r_pcnt != 2'd0) begin
                r_pcnt <= r_pcnt - 2'd1;
            end
            if (adv) begin
                r_s1v <= (r_pcnt != 2'd0) && !accept;
                r_s2v <= r_s1v;
                r_fv  <= ram_we;
            end
            if (ram_we) begin
                r_vld[r_s2.row] <= 1'b1;
            end
            if (adv && r_s2v && r_s2.rd) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop[0] <= dec_op0;
            r_pop[1] <= dec_op1;
        end else if (adv && r_pcnt != 2'd0) begin
            r_pop[0] <= r_pop[1];
        end
        if (adv) begin
            r_s1    <= r_pop[0];
            r_s2    <= r_s1;
            r_s2vld <= r_vld[r_s1.row];
            r_frow  <= r_s2.row;
            r_fdata <= new_row;
        end
        if (adv && r_s2v && r_s2.rd) begin
            r_out.row_data         <= r_s2.hi ? r_s2.hdata : old_row;
            r_out.game_mode_active <= r_s2.gm;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    `KPKM_ASSERT_NOW(a_pcnt_range, 1'b1, r_pcnt <= 2'd2)
    `KPKM_ASSERT_NOW(a_no_write_on_read, r_s2v && r_s2.rd, !ram_we)
    `KPKM_ASSERT_NEXT(a_read_queued, accept && i_item.req_type == REQ_READ, r_pcnt == 2'd1)
    `KPKM_ASSERT_NEXT(a_out_held, r_ov && i_stall, r_ov)
endmodule
